// ===== hw/rtl/ssf_pkg.sv =====
`timescale 1ns / 1ps

package ssf_pkg;

    // Configuration register indexes
    localparam logic REG_TARGET_TYPE  = 1'b0;
    localparam logic REG_TARGET_INDEX = 1'b1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } ssf_in_t;

    typedef struct packed {
        logic        found;
        logic [15:0] start_offset;
    } ssf_out_t;

endpackage

// ===== hw/rtl/smbios_structure_finder.sv =====
`timescale 1ns / 1ps

// Walks an SMBIOS structure table that arrives one byte per input transfer and
// reports the start offset of occurrence target_index (counted from zero) of the
// structures whose type byte equals target_type. A match is reported once the
// byte HEADER_BYTES past its start has arrived; if none is confirmed, the final
// byte of the buffer (last_byte set) produces a not-found result. Each buffer
// gives exactly one result, after which the walk restarts for the next buffer;
// the configuration registers are kept. The block takes one byte every clock
// cycle: each byte is parsed combinationally against the registered walk
// state, and the result sits in an output register, so input stalls only
// while a result is held and not yet taken downstream. Positions saturate at
// the largest POSITION_BITS value, where bytes are no longer parsed.
module smbios_structure_finder
    import ssf_pkg::*;
#(
    parameter int POSITION_BITS = 16,
    parameter int HEADER_BYTES  = 4
)
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       cfg_write_enable,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data,

    input  logic       in_valid,
    output logic       in_ready,
    input  ssf_in_t    in_data,

    output logic       out_valid,
    input  logic       out_ready,
    output ssf_out_t   out_data
);

    localparam int PB = POSITION_BITS;
    localparam int CW = (PB > 8) ? PB : 8;
    localparam logic [PB-1:0] POS_MAX = {PB{1'b1}};

    logic [7:0]    target_type_reg;
    logic [7:0]    target_index_reg;

    logic [PB-1:0] byte_position_reg,     byte_position_next;
    logic [PB-1:0] structure_start_reg,   structure_start_next;
    logic [7:0]    formatted_length_reg,  formatted_length_next;
    logic          previous_was_zero_reg, previous_was_zero_next;
    logic [7:0]    type_match_count_reg,  type_match_count_next;
    logic          match_pending_reg,     match_pending_next;
    logic [PB-1:0] pending_offset_reg,    pending_offset_next;
    logic          search_done_reg,       search_done_next;

    logic          out_valid_reg,         out_valid_next;
    ssf_out_t      out_data_reg,          out_data_next;

    logic          accept;
    logic          emit;
    logic          parse_en;
    logic          byte_zero;
    logic [PB-1:0] rel;
    logic          rel_zero;
    logic          rel_one;
    logic [7:0]    len_eff;
    logic [CW-1:0] rel_ext;
    logic [CW-1:0] len_ext;
    logic [PB:0]   confirm_pos;
    logic          confirm;
    logic [PB+15:0] offset_wide;

    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_type_reg  <= '0;
            target_index_reg <= '0;
        end
        else if (cfg_write_enable)
        begin
            unique case (cfg_index)
                REG_TARGET_TYPE:  target_type_reg  <= cfg_data;
                REG_TARGET_INDEX: target_index_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        byte_zero   = (in_data.data_byte == 8'd0);
        parse_en    = !search_done_reg && (byte_position_reg != POS_MAX);
        rel         = byte_position_reg - structure_start_reg;
        rel_zero    = (rel == '0);
        rel_one     = (rel == PB'(1));
        // The length byte counts for the terminator check on the very byte it arrives.
        len_eff     = rel_one ? in_data.data_byte : formatted_length_reg;
        rel_ext     = CW'(rel);
        len_ext     = CW'(len_eff);
        confirm_pos = {1'b0, pending_offset_reg} + (PB+1)'(HEADER_BYTES);
        confirm     = parse_en && match_pending_reg &&
                      (confirm_pos == {1'b0, byte_position_reg});
        offset_wide = {16'd0, pending_offset_reg};

        byte_position_next     = byte_position_reg;
        structure_start_next   = structure_start_reg;
        formatted_length_next  = formatted_length_reg;
        previous_was_zero_next = previous_was_zero_reg;
        type_match_count_next  = type_match_count_reg;
        match_pending_next     = match_pending_reg;
        pending_offset_next    = pending_offset_reg;
        search_done_next       = search_done_reg;
        emit                   = 1'b0;
        out_data_next          = out_data_reg;

        if (accept)
        begin
            if (parse_en)
            begin
                if (rel_zero)
                begin
                    if (!match_pending_reg && (in_data.data_byte == target_type_reg))
                    begin
                        if (type_match_count_reg == target_index_reg)
                        begin
                            match_pending_next  = 1'b1;
                            pending_offset_next = structure_start_reg;
                        end
                        type_match_count_next = type_match_count_reg + 8'd1;
                    end
                end
                else
                begin
                    if (rel_one)
                    begin
                        formatted_length_next = in_data.data_byte;
                    end
                    if ((rel_ext > len_ext) && previous_was_zero_reg && byte_zero)
                    begin
                        structure_start_next = byte_position_reg + PB'(1);
                    end
                end
                previous_was_zero_next = byte_zero;

                if (confirm)
                begin
                    emit                       = 1'b1;
                    out_data_next.found        = 1'b1;
                    out_data_next.start_offset = offset_wide[15:0];
                    search_done_next           = 1'b1;
                end
            end

            if (byte_position_reg != POS_MAX)
            begin
                byte_position_next = byte_position_reg + PB'(1);
            end

            if (in_data.last_byte)
            begin
                if (!search_done_reg && !confirm)
                begin
                    emit                       = 1'b1;
                    out_data_next.found        = 1'b0;
                    out_data_next.start_offset = 16'd0;
                end
                byte_position_next     = '0;
                structure_start_next   = '0;
                formatted_length_next  = '0;
                previous_was_zero_next = 1'b0;
                type_match_count_next  = '0;
                match_pending_next     = 1'b0;
                pending_offset_next    = '0;
                search_done_next       = 1'b0;
            end
        end

        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_position_reg     <= '0;
            structure_start_reg   <= '0;
            formatted_length_reg  <= '0;
            previous_was_zero_reg <= 1'b0;
            type_match_count_reg  <= '0;
            match_pending_reg     <= 1'b0;
            pending_offset_reg    <= '0;
            search_done_reg       <= 1'b0;
            out_valid_reg         <= 1'b0;
        end
        else
        begin
            byte_position_reg     <= byte_position_next;
            structure_start_reg   <= structure_start_next;
            formatted_length_reg  <= formatted_length_next;
            previous_was_zero_reg <= previous_was_zero_next;
            type_match_count_reg  <= type_match_count_next;
            match_pending_reg     <= match_pending_next;
            pending_offset_reg    <= pending_offset_next;
            search_done_reg       <= search_done_next;
            out_valid_reg         <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    // A finished search always comes from a confirmed pending match.
    assert property (@(posedge clk) disable iff (!rst_n)
        search_done_reg |-> match_pending_reg)
        else $error("search done without a pending match");

    // A pending match never lies ahead of the current byte position.
    assert property (@(posedge clk) disable iff (!rst_n)
        match_pending_reg |-> (pending_offset_reg <= byte_position_reg))
        else $error("pending offset beyond byte position");

    // The final byte of a buffer restarts the walk.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_data.last_byte) |=>
            (byte_position_reg == '0) && !search_done_reg && !match_pending_reg)
        else $error("walk state not cleared after final byte");

    // A not-found result carries a zero offset.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_data_reg.found) |-> (out_data_reg.start_offset == 16'd0))
        else $error("not-found result with nonzero offset");

endmodule

// ===== tb/sv/ssf_walk_checker.sv =====
`timescale 1ns / 1ps

module ssf_walk_checker
    import ssf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       cfg_write_enable,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data,

    input  logic       in_valid,
    input  logic       in_ready,
    input  ssf_in_t    in_data,

    input  logic       out_valid,
    input  logic       out_ready,
    input  ssf_out_t   out_data,

    output int         mismatch_count,
    output int         reports_due,
    output int         reports_checked,
    output int         reports_found
);

    localparam int          POSITION_BITS = 16;
    localparam int          HEADER_BYTES  = 4;
    localparam int unsigned POS_MAX       = (32'd1 << POSITION_BITS) - 1;

    logic [7:0]  search_type;
    logic [7:0]  search_index;

    int unsigned walk_pos;
    int unsigned struct_base;
    logic [7:0]  fmt_length;
    logic        last_was_zero;
    logic [7:0]  hit_count;
    logic        hit_armed;
    int unsigned hit_offset;
    logic        walk_done;

    ssf_out_t    due_reports[$];
    int          mismatches;
    int          checked;
    int          found_seen;

    task automatic restart_walk();
        walk_pos      = 0;
        struct_base   = 0;
        fmt_length    = '0;
        last_was_zero = 1'b0;
        hit_count     = '0;
        hit_armed     = 1'b0;
        hit_offset    = 0;
        walk_done     = 1'b0;
    endtask

    // Advances the table walk by one byte and queues the report it causes, if any.
    task automatic walk_byte(input ssf_in_t item);
        int unsigned rel;
        logic [7:0]  b;
        logic        emit;
        ssf_out_t    report;
        b      = item.data_byte;
        emit   = 1'b0;
        report = '0;
        if (!walk_done && walk_pos < POS_MAX) begin
            rel = (walk_pos - struct_base) & POS_MAX;
            if (rel == 0) begin
                if (!hit_armed && b == search_type) begin
                    if (hit_count == search_index) begin
                        hit_armed  = 1'b1;
                        hit_offset = struct_base;
                    end
                    hit_count = hit_count + 8'd1;
                end
            end
            else begin
                if (rel == 1)
                    fmt_length = b;
                // A zero pair whose first byte lies at or past the formatted end closes it.
                if (rel >= fmt_length + 1 && last_was_zero && b == 8'h00)
                    struct_base = walk_pos + 1;
            end
            last_was_zero = (b == 8'h00);
            if (hit_armed && walk_pos == hit_offset + HEADER_BYTES) begin
                emit                = 1'b1;
                report.found        = 1'b1;
                report.start_offset = hit_offset[15:0];
                walk_done           = 1'b1;
            end
        end
        if (walk_pos < POS_MAX)
            walk_pos = walk_pos + 1;
        if (item.last_byte) begin
            if (!walk_done) begin
                emit   = 1'b1;
                report = '0;
            end
            restart_walk();
        end
        if (emit)
            due_reports.push_back(report);
    endtask

    task automatic check_report(input ssf_out_t seen);
        ssf_out_t want;
        checked++;
        if (seen.found)
            found_seen++;
        if (due_reports.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("tb: unexpected report found=%0b offset=%0d",
                         seen.found, seen.start_offset);
        end
        else begin
            want = due_reports.pop_front();
            if (seen.found !== want.found || seen.start_offset !== want.start_offset) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("tb: report mismatch: expected found=%0b offset=%0d, got found=%0b offset=%0d",
                             want.found, want.start_offset, seen.found, seen.start_offset);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            search_type  = '0;
            search_index = '0;
            restart_walk();
            due_reports.delete();
            mismatches      = 0;
            checked         = 0;
            found_seen      = 0;
            mismatch_count  <= 0;
            reports_due     <= 0;
            reports_checked <= 0;
            reports_found   <= 0;
        end
        else begin
            if (in_valid && in_ready)
                walk_byte(in_data);
            if (out_valid && out_ready)
                check_report(out_data);
            if (cfg_write_enable) begin
                case (cfg_index)
                    REG_TARGET_TYPE:  search_type  = cfg_data;
                    REG_TARGET_INDEX: search_index = cfg_data;
                    default: ;
                endcase
            end
            mismatch_count  <= mismatches;
            reports_due     <= due_reports.size();
            reports_checked <= checked;
            reports_found   <= found_seen;
        end
    end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    import ssf_pkg::*;

    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int HOLD_CYCLES = 400;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_write_enable;
    logic       cfg_index;
    logic [7:0] cfg_data;
    logic       in_valid;
    logic       in_ready;
    ssf_in_t    in_data;
    logic       out_valid;
    logic       out_ready;
    ssf_out_t   out_data;

    int         mismatch_count;
    int         reports_due;
    int         reports_checked;
    int         reports_found;

    int         sender_idle_pct = 0;
    int         recv_stall_pct  = 0;
    bit         long_hold_req   = 1'b0;
    int         bytes_sent      = 0;
    int         settings_used   = 0;
    logic [7:0] table_bytes[$];

    smbios_structure_finder i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .in_data          (in_data),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .out_data         (out_data)
    );

    ssf_walk_checker i_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .in_data          (in_data),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .out_data         (out_data),
        .mismatch_count   (mismatch_count),
        .reports_due      (reports_due),
        .reports_checked  (reports_checked),
        .reports_found    (reports_found)
    );

    always #5 clk = ~clk;

    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    // Downstream side; a requested long hold is counted out here, and input stalls once a result is held.
    initial
    begin : receiver
        int held;
        out_ready = 1'b0;
        forever begin
            @(posedge clk);
            if (long_hold_req) begin
                out_ready <= 1'b0;
                for (held = 0; held < HOLD_CYCLES; held++)
                    @(posedge clk);
                long_hold_req = 1'b0;
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic set_search(input logic [7:0] type_code, input logic [7:0] occurrence);
        cfg_write_enable <= 1'b1;
        cfg_index        <= REG_TARGET_TYPE;
        cfg_data         <= type_code;
        @(posedge clk);
        cfg_index        <= REG_TARGET_INDEX;
        cfg_data         <= occurrence;
        @(posedge clk);
        cfg_write_enable <= 1'b0;
        settings_used++;
    endtask

    // Valid is left high after a transfer; the next call lowers it only for a gap.
    task automatic send_byte(input logic [7:0] value, input logic end_flag);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < sender_idle_pct)
            gap++;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= ssf_in_t'{data_byte: value, last_byte: end_flag};
        do
            @(posedge clk);
        while (!in_ready);
        bytes_sent++;
    endtask

    task automatic send_table();
        int i;
        for (i = 0; i < table_bytes.size(); i++)
            send_byte(table_bytes[i], i == table_bytes.size() - 1);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (reports_due != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Mostly well-formed tables with random content; some noise and truncated tables.
    task automatic build_table(input logic [7:0] hot_type);
        int n_structs;
        int fmt_len;
        int n_strings;
        int i;
        int cut;
        logic [7:0] kind;
        table_bytes.delete();
        if ($urandom_range(99) < 8) begin
            repeat ($urandom_range(1, 30))
                table_bytes.push_back(($urandom_range(3) == 0) ? 8'h00 : 8'($urandom));
            return;
        end
        n_structs = $urandom_range(1, 5);
        repeat (n_structs) begin
            kind = ($urandom_range(99) < 45) ? hot_type : 8'($urandom);
            case ($urandom_range(9))
                0:       fmt_len = $urandom_range(0, 1);
                1:       fmt_len = $urandom_range(2, 3);
                2:       fmt_len = ($urandom_range(9) == 0) ? 255 : $urandom_range(17, 40);
                default: fmt_len = $urandom_range(4, 16);
            endcase
            table_bytes.push_back(kind);
            table_bytes.push_back(8'(fmt_len));
            for (i = 2; i < fmt_len; i++)
                table_bytes.push_back(($urandom_range(99) < 15) ? 8'h00 : 8'($urandom));
            n_strings = $urandom_range(0, 3);
            if (n_strings == 0)
                table_bytes.push_back(8'h00);
            repeat (n_strings) begin
                repeat ($urandom_range(1, 6))
                    table_bytes.push_back(8'($urandom_range(1, 255)));
                table_bytes.push_back(8'h00);
            end
            table_bytes.push_back(8'h00);
        end
        if ($urandom_range(99) < 10) begin
            cut = $urandom_range(1, table_bytes.size());
            while (table_bytes.size() > cut)
                void'(table_bytes.pop_back());
        end
        if ($urandom_range(99) < 5)
            table_bytes.insert($urandom_range(0, table_bytes.size()), 8'($urandom));
    endtask

    task automatic run_phase(input int send_idle, input int recv_stall, input bit squeeze);
        int         seg;
        int         budget_end;
        logic [7:0] type_code;
        logic [7:0] occurrence;
        sender_idle_pct = send_idle;
        recv_stall_pct  = recv_stall;
        for (seg = 0; seg < 4; seg++) begin
            case ($urandom_range(5))
                0:       type_code = 8'h00;
                1:       type_code = 8'hFF;
                default: type_code = 8'($urandom);
            endcase
            case ($urandom_range(7))
                0:       occurrence = 8'hFF;
                1:       occurrence = 8'($urandom);
                default: occurrence = 8'($urandom_range(0, 2));
            endcase
            set_search(type_code, occurrence);
            if (squeeze && seg == 0)
                long_hold_req = 1'b1;
            budget_end = bytes_sent + 85;
            while (bytes_sent < budget_end) begin
                build_table(type_code);
                send_table();
            end
            settle();
        end
    endtask

    initial
    begin : stimulus
        int pos;
        logic [7:0] value;
        rst_n            = 1'b0;
        cfg_write_enable = 1'b0;
        cfg_index        = REG_TARGET_TYPE;
        cfg_data         = 8'h00;
        in_valid         = 1'b0;
        in_data          = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset search settings: a lone final byte cannot confirm the match at offset zero.
        table_bytes = '{8'h00};
        send_table();
        // The confirming byte is the final byte itself.
        table_bytes = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
        send_table();
        settle();

        // Length 1 and length 0 structures, then bytes ignored after the report.
        set_search(8'hFF, 8'd1);
        table_bytes = '{8'hFF, 8'h01, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h42, 8'hA5};
        send_table();
        table_bytes = '{8'h80, 8'h04, 8'h7F, 8'h55, 8'h00, 8'h00, 8'hFF};
        send_table();
        settle();

        // The occurrence counter has to reach 255 before the match.
        set_search(8'hFF, 8'hFF);
        table_bytes.delete();
        repeat (257) begin
            table_bytes.push_back(8'hFF);
            table_bytes.push_back(8'h00);
            table_bytes.push_back(8'h00);
        end
        send_table();
        settle();

        // One structure spans almost the whole position range; the match found right
        // before the position saturates can never be confirmed.
        set_search(8'h7E, 8'd1);
        for (pos = 0; pos < 65540; pos++) begin
            if (pos == 0 || pos == 65532)
                value = 8'h7E;
            else if (pos == 1)
                value = 8'hFF;
            else if (pos == 65530 || pos == 65531)
                value = 8'h00;
            else if (pos > 65532)
                value = 8'h33;
            else
                value = 8'h55;
            send_byte(value, pos == 65539);
        end
        settle();

        run_phase(0, 0, 1'b1);
        run_phase(74, 0, 1'b0);
        run_phase(0, 74, 1'b0);
        run_phase(7, 7, 1'b0);
        run_phase(0, 0, 1'b0);

        settle();
        repeat (8) @(posedge clk);
        $display("tb: %0d bytes sent under %0d search settings", bytes_sent, settings_used);
        $display("tb: %0d reports checked, %0d of them matches found",
                 reports_checked, reports_found);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
